>>> design/tssb_pkg.sv
// Shared types and constants for the three-stack shared buffer.
// No dependencies; compiled first.
package tssb_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CAP_W          = 9;
    localparam int VALUE_W        = 32;

    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_PEEK = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_INVALID   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        STK_LOW     = 2'd0,
        STK_HIGH    = 2'd1,
        STK_MID     = 2'd2,
        STK_INVALID = 2'd3
    } t_stack;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MV_RD,
        S_MV_WR,
        S_PUSH
    } t_state;

endpackage

>>> design/tssb_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on tssb_pkg.
interface tssb_req_if;
    logic                           valid;
    logic                           ready;
    tssb_pkg::t_action              action;
    tssb_pkg::t_stack               stack_id;
    logic signed [tssb_pkg::VALUE_W-1:0] push_value;

    modport source (output valid, output action, output stack_id, output push_value,
                    input ready);
    modport sink   (input valid, input action, input stack_id, input push_value,
                    output ready);
endinterface

interface tssb_rsp_if;
    logic                           valid;
    logic                           ready;
    tssb_pkg::t_status              status;
    logic signed [tssb_pkg::VALUE_W-1:0] read_value;

    modport source (output valid, output status, output read_value, input ready);
    modport sink   (input valid, input status, input read_value, output ready);
endinterface

>>> design/three_stacks_shared_buffer_unit.sv
// Three stacks sharing one synchronous word memory, with stack relocation.
// Depends on tssb_pkg and the channel interfaces in tssb_if.sv.
//
// Usage:
//   i_req carries one request beat (action, stack_id, push_value); o_rsp
//   returns exactly one beat (status, read_value) per request, in order.
//   i_cfg_wr_en/i_cfg_wr_data write the capacity (clamped to 1..DEPTH),
//   which empties all three stacks and rebases stack 2 at capacity/2.
//   Write it only while no request is outstanding.
// Sequence:
//   Push, rejected requests: response valid in the cycle after acceptance;
//   a next request may follow in the next cycle while o_rsp.ready is high.
//   Pop/peek: one memory read into r_rdata (S_READ), then the response register.
//   Push that moves stack 2: one read (S_MV_RD) and one write (S_MV_WR) per word of
//   stack 2, then the push write (S_PUSH), which loads the response register.
//   The single memory port pair sets this order.
// Reset: stacks empty, capacity DEPTH, memory contents left undefined.
// Stall: the response register holds its beat while o_rsp.ready is low;
//   a new request is taken only when that register is empty or draining.
module three_stacks_shared_buffer_unit #(
    parameter int DEPTH      = tssb_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = tssb_pkg::DATA_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [tssb_pkg::CAP_W-1:0] i_cfg_wr_data,
    tssb_req_if.sink                  i_req,
    tssb_rsp_if.source                o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int SW = CW + 2;
    localparam int KW = (CW > tssb_pkg::CAP_W) ? CW : tssb_pkg::CAP_W;
    localparam int XW = (DATA_WIDTH > tssb_pkg::VALUE_W) ? DATA_WIDTH : tssb_pkg::VALUE_W;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    tssb_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_cap, n_cap, r_cl, n_cl, r_ch, n_ch, r_cm, n_cm, r_mb, n_mb;
    logic [CW-1:0] r_src, n_src, r_shift, n_shift, r_left, n_left, r_paddr, n_paddr;
    logic          r_up, n_up;
    logic [DATA_WIDTH-1:0] r_pdata, n_pdata;
    logic          r_out_valid, n_out_valid;
    tssb_pkg::t_status r_status, n_status;
    logic [tssb_pkg::VALUE_W-1:0] r_rvalue, n_rvalue;

    logic          mem_we, mem_re;
    logic [CW-1:0] mem_waddr, mem_raddr;
    logic [DATA_WIDTH-1:0] mem_wdata;

    logic          acc;
    logic [SW-1:0] used, free_w, shift_w;
    logic [CW-1:0] shift_up, shift_dn, new_mb, push_addr, top_addr, cnt_sel;
    logic          blk_low, blk_high, invalid;
    logic [XW-1:0] pv_ext, rd_ext;
    logic [KW-1:0] cfg_v;

    assign i_req.ready  = (r_state == tssb_pkg::S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign acc          = i_req.valid && i_req.ready;
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_status;
    assign o_rsp.read_value = r_rvalue;

    assign pv_ext = XW'($unsigned(i_req.push_value));
    assign rd_ext = XW'(r_rdata);

    assign used     = SW'(r_cl) + SW'(r_ch) + SW'(r_cm);
    assign free_w   = (SW'(r_cap) > used) ? SW'(r_cap) - used : '0;
    assign shift_w  = (free_w + SW'(1)) >> 1;
    assign shift_up = CW'(shift_w);
    assign shift_dn = (shift_up > r_mb) ? r_mb : shift_up;
    assign invalid  = (i_req.stack_id == tssb_pkg::STK_INVALID)
                   || !((i_req.action == tssb_pkg::ACT_PUSH)
                     || (i_req.action == tssb_pkg::ACT_POP)
                     || (i_req.action == tssb_pkg::ACT_PEEK));
    assign blk_low  = (i_req.stack_id == tssb_pkg::STK_LOW) && (r_cl == r_mb);
    assign blk_high = (i_req.stack_id != tssb_pkg::STK_LOW)
                   && ((SW'(r_mb) + SW'(r_cm) + SW'(r_ch)) == SW'(r_cap));
    assign new_mb   = blk_low ? r_mb + shift_up : (blk_high ? r_mb - shift_dn : r_mb);

    always_comb begin
        case (i_req.stack_id)
            tssb_pkg::STK_LOW: begin
                push_addr = r_cl;
                top_addr  = r_cl - CW'(1);
                cnt_sel   = r_cl;
            end
            tssb_pkg::STK_HIGH: begin
                push_addr = r_cap - CW'(1) - r_ch;
                top_addr  = r_cap - r_ch;
                cnt_sel   = r_ch;
            end
            default: begin
                push_addr = new_mb + r_cm;
                top_addr  = r_mb + r_cm - CW'(1);
                cnt_sel   = r_cm;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cap       = r_cap;
        n_cl        = r_cl;
        n_ch        = r_ch;
        n_cm        = r_cm;
        n_mb        = r_mb;
        n_src       = r_src;
        n_shift     = r_shift;
        n_left      = r_left;
        n_paddr     = r_paddr;
        n_up        = r_up;
        n_pdata     = r_pdata;
        n_status    = r_status;
        n_rvalue    = r_rvalue;
        n_out_valid = r_out_valid && !o_rsp.ready;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_paddr;
        mem_raddr   = r_src;
        mem_wdata   = r_pdata;
        cfg_v       = KW'(i_cfg_wr_data);

        case (r_state)
            tssb_pkg::S_IDLE: begin
                if (acc) begin
                    if (invalid) begin
                        n_out_valid = 1'b1;
                        n_status    = tssb_pkg::ST_INVALID;
                        n_rvalue    = '0;
                    end else if (i_req.action == tssb_pkg::ACT_PUSH) begin
                        if (used >= SW'(r_cap)) begin
                            n_out_valid = 1'b1;
                            n_status    = tssb_pkg::ST_OVERFLOW;
                            n_rvalue    = '0;
                        end else begin
                            n_mb    = new_mb;
                            n_paddr = push_addr;
                            n_pdata = pv_ext[DATA_WIDTH-1:0];
                            case (i_req.stack_id)
                                tssb_pkg::STK_LOW:  n_cl = r_cl + CW'(1);
                                tssb_pkg::STK_HIGH: n_ch = r_ch + CW'(1);
                                default:            n_cm = r_cm + CW'(1);
                            endcase
                            if ((blk_low || blk_high) && (r_cm != '0)) begin
                                n_up    = blk_low;
                                n_shift = blk_low ? shift_up : shift_dn;
                                n_src   = blk_low ? r_mb + r_cm - CW'(1) : r_mb;
                                n_left  = r_cm;
                                n_state = tssb_pkg::S_MV_RD;
                            end else begin
                                mem_we      = 1'b1;
                                mem_waddr   = push_addr;
                                mem_wdata   = pv_ext[DATA_WIDTH-1:0];
                                n_out_valid = 1'b1;
                                n_status    = tssb_pkg::ST_OK;
                                n_rvalue    = '0;
                            end
                        end
                    end else begin
                        if (cnt_sel == '0) begin
                            n_out_valid = 1'b1;
                            n_status    = tssb_pkg::ST_UNDERFLOW;
                            n_rvalue    = '0;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = top_addr;
                            n_state   = tssb_pkg::S_READ;
                            if (i_req.action == tssb_pkg::ACT_POP) begin
                                case (i_req.stack_id)
                                    tssb_pkg::STK_LOW:  n_cl = r_cl - CW'(1);
                                    tssb_pkg::STK_HIGH: n_ch = r_ch - CW'(1);
                                    default:            n_cm = r_cm - CW'(1);
                                endcase
                            end
                        end
                    end
                end
            end
            tssb_pkg::S_READ: begin
                n_out_valid = 1'b1;
                n_status    = tssb_pkg::ST_OK;
                n_rvalue    = rd_ext[tssb_pkg::VALUE_W-1:0];
                n_state     = tssb_pkg::S_IDLE;
            end
            tssb_pkg::S_MV_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_src;
                n_state   = tssb_pkg::S_MV_WR;
            end
            tssb_pkg::S_MV_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_up ? r_src + r_shift : r_src - r_shift;
                mem_wdata = r_rdata;
                n_left    = r_left - CW'(1);
                n_src     = r_up ? r_src - CW'(1) : r_src + CW'(1);
                n_state   = (r_left == CW'(1)) ? tssb_pkg::S_PUSH : tssb_pkg::S_MV_RD;
            end
            tssb_pkg::S_PUSH: begin
                mem_we      = 1'b1;
                mem_waddr   = r_paddr;
                mem_wdata   = r_pdata;
                n_out_valid = 1'b1;
                n_status    = tssb_pkg::ST_OK;
                n_rvalue    = '0;
                n_state     = tssb_pkg::S_IDLE;
            end
            default: begin
                n_state = tssb_pkg::S_IDLE;
            end
        endcase

        if (i_cfg_wr_en) begin
            if (cfg_v == '0) begin
                cfg_v = KW'(1);
            end else if (cfg_v > KW'(DEPTH)) begin
                cfg_v = KW'(DEPTH);
            end
            n_cap = CW'(cfg_v);
            n_cl  = '0;
            n_ch  = '0;
            n_cm  = '0;
            n_mb  = CW'(cfg_v) >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tssb_pkg::S_IDLE;
            r_cap       <= CW'(DEPTH);
            r_cl        <= '0;
            r_ch        <= '0;
            r_cm        <= '0;
            r_mb        <= CW'(DEPTH / 2);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cap       <= n_cap;
            r_cl        <= n_cl;
            r_ch        <= n_ch;
            r_cm        <= n_cm;
            r_mb        <= n_mb;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src    <= n_src;
        r_shift  <= n_shift;
        r_left   <= n_left;
        r_paddr  <= n_paddr;
        r_up     <= n_up;
        r_pdata  <= n_pdata;
        r_status <= n_status;
        r_rvalue <= n_rvalue;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr[AW-1:0]] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr[AW-1:0]];
        end
    end

endmodule
